// ----- src/gaps_pkg.sv -----
// Shared types, codes and tables of the grid path search core.
// No dependencies; used by gaps_ctrl, gaps_datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none
package gaps_pkg;

  localparam int MAX_DIM = 64;
  localparam int DIM_W   = $clog2(MAX_DIM);
  localparam int CELLS   = MAX_DIM * MAX_DIM;
  localparam int ADDR_W  = 2 * DIM_W;
  localparam int POS_W   = 6;   // field width of a row or column
  localparam int SIZE_W  = 7;   // field width of a grid size
  localparam int COST_W  = 12;
  localparam int CFG_W   = 7;
  localparam int CFGI_W  = 3;

  localparam logic [COST_W-1:0] COST_MAX = '1;

  // register indexes
  localparam logic [CFGI_W-1:0] REG_ROWS      = 3'd0;
  localparam logic [CFGI_W-1:0] REG_COLS      = 3'd1;
  localparam logic [CFGI_W-1:0] REG_START_ROW = 3'd2;
  localparam logic [CFGI_W-1:0] REG_START_COL = 3'd3;
  localparam logic [CFGI_W-1:0] REG_GOAL_ROW  = 3'd4;
  localparam logic [CFGI_W-1:0] REG_GOAL_COL  = 3'd5;

  // input modes
  localparam logic [1:0] MODE_WRITE  = 2'd0;
  localparam logic [1:0] MODE_SEARCH = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;
  localparam logic [1:0] MODE_NONE   = 2'd3;

  // result status codes
  localparam logic [2:0] ST_WRITTEN = 3'd0;
  localparam logic [2:0] ST_FOUND   = 3'd1;
  localparam logic [2:0] ST_NOPATH  = 3'd2;
  localparam logic [2:0] ST_PARENT  = 3'd3;
  localparam logic [2:0] ST_INVALID = 3'd4;

  // cell marks
  localparam logic [1:0] MARK_UNSEEN = 2'd0;
  localparam logic [1:0] MARK_OPEN   = 2'd1;
  localparam logic [1:0] MARK_CLOSED = 2'd2;

  localparam logic signed [7:0] ROW_OFF [0:7] = '{0, 1, 0, -1, 1, -1, -1, 1};
  localparam logic signed [7:0] COL_OFF [0:7] = '{-1, 0, 1, 0, 1, -1, 1, -1};
  localparam logic [2:0] REV_DIR [0:7] = '{3'd2, 3'd3, 3'd0, 3'd1, 3'd5, 3'd4, 3'd7, 3'd6};

  typedef enum logic [4:0] {
    OP_IDLE, OP_CLEAR, OP_CLRMARK, OP_WRITE, OP_READ_RD, OP_READ_EV,
    OP_CHK_S, OP_CHK_G, OP_INIT, OP_BAD, OP_SCAN_INIT, OP_SCAN,
    OP_NOPATH, OP_CLOSE, OP_NB_RD, OP_NB_EV, OP_EMIT
  } gaps_op_t;

  typedef struct packed {
    gaps_op_t op;
    logic     latch;   // capture the input word
  } gaps_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic sg_ok;
    logic same;
    logic scan_done;
    logic any;
    logic nb_goal;
    logic nb_last;
    logic out_free;
  } gaps_stat_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [POS_W-1:0] r,
                                                  input logic [POS_W-1:0] c);
    cell_addr = ADDR_W'(int'(r) * MAX_DIM + int'(c));
  endfunction

endpackage
`default_nettype wire

// ----- src/gaps_ctrl.sv -----
// Controller state machine of the grid path search core.
// Depends on gaps_pkg; drives gaps_datapath through command words.
`timescale 1ns / 1ps
`default_nettype none
module gaps_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic [1:0]         mode,
  input  var  gaps_pkg::gaps_stat_t stat,
  output var  gaps_pkg::gaps_cmd_t  cmd,
  output logic                    in_ready
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_WRITE, S_READ_RD, S_READ_EV, S_CLRMARK, S_CHK_S,
    S_CHK_G, S_CHK_END, S_SCAN_INIT, S_SCAN, S_PICK, S_NB_RD, S_NB_EV, S_EMIT
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd.op     = gaps_pkg::OP_IDLE;
    cmd.latch  = 1'b0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.op = gaps_pkg::OP_CLEAR;
        if (stat.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.latch = in_valid;
        if (in_valid) begin
          unique case (mode)
            gaps_pkg::MODE_WRITE:  state_next = S_WRITE;
            gaps_pkg::MODE_SEARCH: state_next = S_CLRMARK;
            gaps_pkg::MODE_READ:   state_next = S_READ_RD;
            gaps_pkg::MODE_NONE:   state_next = S_IDLE;
          endcase
        end
      end
      S_WRITE: begin
        cmd.op = gaps_pkg::OP_WRITE;
        state_next = S_EMIT;
      end
      S_READ_RD: begin
        cmd.op = gaps_pkg::OP_READ_RD;
        state_next = S_READ_EV;
      end
      S_READ_EV: begin
        cmd.op = gaps_pkg::OP_READ_EV;
        state_next = S_EMIT;
      end
      S_CLRMARK: begin
        cmd.op = gaps_pkg::OP_CLRMARK;
        if (stat.sweep_last) state_next = S_CHK_S;
      end
      S_CHK_S: begin
        cmd.op = gaps_pkg::OP_CHK_S;
        state_next = S_CHK_G;
      end
      S_CHK_G: begin
        cmd.op = gaps_pkg::OP_CHK_G;
        state_next = S_CHK_END;
      end
      S_CHK_END: begin
        if (!stat.sg_ok) begin
          cmd.op = gaps_pkg::OP_BAD;
          state_next = S_EMIT;
        end else begin
          cmd.op = gaps_pkg::OP_INIT;
          state_next = stat.same ? S_EMIT : S_SCAN_INIT;
        end
      end
      S_SCAN_INIT: begin
        cmd.op = gaps_pkg::OP_SCAN_INIT;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.op = gaps_pkg::OP_SCAN;
        if (stat.scan_done) state_next = S_PICK;
      end
      S_PICK: begin
        if (!stat.any) begin
          cmd.op = gaps_pkg::OP_NOPATH;
          state_next = S_EMIT;
        end else begin
          cmd.op = gaps_pkg::OP_CLOSE;
          state_next = S_NB_RD;
        end
      end
      S_NB_RD: begin
        cmd.op = gaps_pkg::OP_NB_RD;
        state_next = S_NB_EV;
      end
      S_NB_EV: begin
        cmd.op = gaps_pkg::OP_NB_EV;
        priority if (stat.nb_goal) state_next = S_EMIT;
        else if (stat.nb_last)     state_next = S_SCAN_INIT;
        else                       state_next = S_NB_RD;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.op = gaps_pkg::OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule
`default_nettype wire

// ----- src/gaps_datapath.sv -----
// Datapath of the grid path search core: grid memories, scan and
// neighbour units, config registers and output register. Depends on gaps_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gaps_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  var  gaps_pkg::gaps_cmd_t          cmd,
  output var  gaps_pkg::gaps_stat_t         stat,
  input  wire logic                         cfg_we,
  input  wire logic [gaps_pkg::CFGI_W-1:0]  cfg_index,
  input  wire logic [gaps_pkg::CFG_W-1:0]   cfg_data,
  input  wire logic [gaps_pkg::POS_W-1:0]   cell_row,
  input  wire logic [gaps_pkg::POS_W-1:0]   cell_col,
  input  wire logic                         passable,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [2:0]                        status,
  output logic [gaps_pkg::COST_W-1:0]       path_cost,
  output logic [2:0]                        parent_dir,
  output logic                              reached
);

  localparam int PW = gaps_pkg::POS_W;
  localparam int SW = gaps_pkg::SIZE_W;
  localparam int AW = gaps_pkg::ADDR_W;
  localparam int CW = gaps_pkg::COST_W;

  // config
  logic [SW-1:0] grid_rows, grid_cols;
  logic [PW-1:0] start_row, start_col, goal_row, goal_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= SW'(gaps_pkg::MAX_DIM);
      grid_cols <= SW'(gaps_pkg::MAX_DIM);
      start_row <= '0;
      start_col <= '0;
      goal_row  <= '0;
      goal_col  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gaps_pkg::REG_ROWS:      grid_rows <= cfg_data[SW-1:0];
        gaps_pkg::REG_COLS:      grid_cols <= cfg_data[SW-1:0];
        gaps_pkg::REG_START_ROW: start_row <= cfg_data[PW-1:0];
        gaps_pkg::REG_START_COL: start_col <= cfg_data[PW-1:0];
        gaps_pkg::REG_GOAL_ROW:  goal_row  <= cfg_data[PW-1:0];
        gaps_pkg::REG_GOAL_COL:  goal_col  <= cfg_data[PW-1:0];
        default: ;
      endcase
    end
  end

  logic [SW-1:0] eff_rows, eff_cols;
  assign eff_rows = (grid_rows > SW'(gaps_pkg::MAX_DIM)) ? SW'(gaps_pkg::MAX_DIM) : grid_rows;
  assign eff_cols = (grid_cols > SW'(gaps_pkg::MAX_DIM)) ? SW'(gaps_pkg::MAX_DIM) : grid_cols;

  // latched input word
  logic [PW-1:0] lat_r, lat_c;
  logic          lat_pass;
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      lat_r    <= cell_row;
      lat_c    <= cell_col;
      lat_pass <= passable;
    end
  end

  // grid memories
  logic           mem_free [gaps_pkg::CELLS];
  logic [1:0]     mem_mark [gaps_pkg::CELLS];
  logic [CW-1:0]  mem_cost [gaps_pkg::CELLS];
  logic [2:0]     mem_par  [gaps_pkg::CELLS];
  logic           q_free;
  logic [1:0]     q_mark;
  logic [CW-1:0]  q_cost;
  logic [2:0]     q_par;

  logic [AW-1:0]  rd_addr, wr_addr;
  logic           we_free, we_mark, we_cost, we_par;
  logic           wd_free;
  logic [1:0]     wd_mark;
  logic [CW-1:0]  wd_cost;
  logic [2:0]     wd_par;

  always_ff @(posedge clk) begin
    if (we_free) mem_free[wr_addr] <= wd_free;
    if (we_mark) mem_mark[wr_addr] <= wd_mark;
    if (we_cost) mem_cost[wr_addr] <= wd_cost;
    if (we_par)  mem_par[wr_addr]  <= wd_par;
    q_free <= mem_free[rd_addr];
    q_mark <= mem_mark[rd_addr];
    q_cost <= mem_cost[rd_addr];
    q_par  <= mem_par[rd_addr];
  end

  // control registers
  logic [AW-1:0] cnt;
  logic [PW-1:0] scan_r, scan_c, pr, pc;
  logic          issue_done, pv;
  logic          any;
  logic [CW:0]   best_f;
  logic [PW-1:0] best_r, best_c;
  logic [CW-1:0] best_g;
  logic [2:0]    k;
  logic [PW-1:0] n_r, n_c;
  logic          n_in;
  logic          s_ok;

  // result being built
  logic [2:0]    res_status;
  logic [CW-1:0] res_cost;
  logic [2:0]    res_dir;
  logic          res_reached;

  function automatic logic in_grid(input logic [PW-1:0] r, input logic [PW-1:0] c,
                                   input logic [SW-1:0] nr, input logic [SW-1:0] nc);
    in_grid = (SW'(r) < nr) && (SW'(c) < nc);
  endfunction

  // Manhattan distance of the scanned cell to the goal
  logic [PW-1:0] dr, dc;
  logic [CW:0]   f_cur;
  assign dr    = (pr >= goal_row) ? pr - goal_row : goal_row - pr;
  assign dc    = (pc >= goal_col) ? pc - goal_col : goal_col - pc;
  assign f_cur = (CW+1)'(q_cost) + (CW+1)'(dr) + (CW+1)'(dc);

  // neighbour position
  logic signed [7:0] nr_s, nc_s;
  logic              nb_in;
  assign nr_s  = $signed({2'b00, best_r}) + gaps_pkg::ROW_OFF[k];
  assign nc_s  = $signed({2'b00, best_c}) + gaps_pkg::COL_OFF[k];
  assign nb_in = (nr_s >= 0) && (nc_s >= 0) &&
                 (nr_s < $signed({1'b0, eff_rows})) && (nc_s < $signed({1'b0, eff_cols}));

  logic [CW:0] ng;
  logic        n_use, n_goal, n_better;
  assign ng       = (CW+1)'(best_g) + 1'b1;
  assign n_use    = n_in && q_free;
  assign n_goal   = (n_r == goal_row) && (n_c == goal_col);
  assign n_better = (q_mark == gaps_pkg::MARK_UNSEEN) || (ng < (CW+1)'(q_cost));

  logic same, out_free;
  assign same     = (start_row == goal_row) && (start_col == goal_col);
  assign out_free = !out_valid || out_ready;

  assign stat.sweep_last = &cnt;
  assign stat.sg_ok      = s_ok && in_grid(goal_row, goal_col, eff_rows, eff_cols) && q_free;
  assign stat.same       = same;
  assign stat.scan_done  = issue_done && !pv;
  assign stat.any        = any;
  assign stat.nb_goal    = n_use && n_goal;
  assign stat.nb_last    = (k == 3'd7);
  assign stat.out_free   = out_free;

  // memory ports
  always_comb begin
    rd_addr = '0;
    wr_addr = '0;
    we_free = 1'b0;
    we_mark = 1'b0;
    we_cost = 1'b0;
    we_par  = 1'b0;
    wd_free = 1'b0;
    wd_mark = gaps_pkg::MARK_UNSEEN;
    wd_cost = '0;
    wd_par  = '0;
    unique case (cmd.op)
      gaps_pkg::OP_CLEAR: begin
        wr_addr = cnt;
        we_free = 1'b1;
        we_mark = 1'b1;
      end
      gaps_pkg::OP_CLRMARK: begin
        wr_addr = cnt;
        we_mark = 1'b1;
      end
      gaps_pkg::OP_WRITE: begin
        wr_addr = gaps_pkg::cell_addr(lat_r, lat_c);
        we_free = 1'b1;
        wd_free = lat_pass;
      end
      gaps_pkg::OP_READ_RD: rd_addr = gaps_pkg::cell_addr(lat_r, lat_c);
      gaps_pkg::OP_CHK_S:   rd_addr = gaps_pkg::cell_addr(start_row, start_col);
      gaps_pkg::OP_CHK_G:   rd_addr = gaps_pkg::cell_addr(goal_row, goal_col);
      gaps_pkg::OP_INIT: begin
        wr_addr = gaps_pkg::cell_addr(start_row, start_col);
        we_mark = 1'b1;
        we_cost = 1'b1;
        we_par  = 1'b1;
        wd_mark = same ? gaps_pkg::MARK_CLOSED : gaps_pkg::MARK_OPEN;
      end
      gaps_pkg::OP_SCAN:  rd_addr = gaps_pkg::cell_addr(scan_r, scan_c);
      gaps_pkg::OP_CLOSE: begin
        wr_addr = gaps_pkg::cell_addr(best_r, best_c);
        we_mark = 1'b1;
        wd_mark = gaps_pkg::MARK_CLOSED;
      end
      gaps_pkg::OP_NB_RD: rd_addr = gaps_pkg::cell_addr(nr_s[PW-1:0], nc_s[PW-1:0]);
      gaps_pkg::OP_NB_EV: begin
        wr_addr = gaps_pkg::cell_addr(n_r, n_c);
        if (n_use && (n_goal || n_better)) begin
          we_mark = 1'b1;
          we_cost = 1'b1;
          we_par  = 1'b1;
        end
        wd_mark = n_goal ? gaps_pkg::MARK_CLOSED : gaps_pkg::MARK_OPEN;
        wd_cost = ng[CW-1:0];
        wd_par  = gaps_pkg::REV_DIR[k];
      end
      default: ;
    endcase
  end

  // sequencing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
      pv        <= 1'b0;
    end else begin
      // emit loads the output register; a taken word clears valid
      out_valid <= (cmd.op == gaps_pkg::OP_EMIT) || (out_valid && !out_ready);
      unique case (cmd.op)
        gaps_pkg::OP_CLEAR, gaps_pkg::OP_CLRMARK: cnt <= cnt + 1'b1;
        gaps_pkg::OP_WRITE: begin
          res_status  <= gaps_pkg::ST_WRITTEN;
          res_cost    <= '0;
          res_dir     <= '0;
          res_reached <= 1'b0;
        end
        gaps_pkg::OP_READ_EV: begin
          res_status <= gaps_pkg::ST_PARENT;
          if (in_grid(lat_r, lat_c, eff_rows, eff_cols) &&
              (q_mark != gaps_pkg::MARK_UNSEEN)) begin
            res_cost    <= q_cost;
            res_dir     <= q_par;
            res_reached <= 1'b1;
          end else begin
            res_cost    <= '0;
            res_dir     <= '0;
            res_reached <= 1'b0;
          end
        end
        gaps_pkg::OP_CHK_G: s_ok <= in_grid(start_row, start_col, eff_rows, eff_cols) && q_free;
        gaps_pkg::OP_INIT, gaps_pkg::OP_BAD, gaps_pkg::OP_NOPATH: begin
          res_status  <= (cmd.op == gaps_pkg::OP_INIT)   ? gaps_pkg::ST_FOUND :
                         (cmd.op == gaps_pkg::OP_NOPATH) ? gaps_pkg::ST_NOPATH :
                                                           gaps_pkg::ST_INVALID;
          res_cost    <= '0;
          res_dir     <= '0;
          res_reached <= 1'b0;
        end
        gaps_pkg::OP_SCAN_INIT: begin
          scan_r     <= '0;
          scan_c     <= '0;
          issue_done <= 1'b0;
          pv         <= 1'b0;
          any        <= 1'b0;
        end
        gaps_pkg::OP_SCAN: begin
          pv <= !issue_done;
          pr <= scan_r;
          pc <= scan_c;
          if (!issue_done) begin
            if (SW'(scan_c) + 1'b1 == eff_cols) begin
              scan_c <= '0;
              if (SW'(scan_r) + 1'b1 == eff_rows) issue_done <= 1'b1;
              else                                scan_r     <= scan_r + 1'b1;
            end else begin
              scan_c <= scan_c + 1'b1;
            end
          end
          // strict compare keeps the lowest index on ties
          if (pv && (q_mark == gaps_pkg::MARK_OPEN) && (!any || f_cur < best_f)) begin
            any    <= 1'b1;
            best_f <= f_cur;
            best_r <= pr;
            best_c <= pc;
            best_g <= q_cost;
          end
        end
        gaps_pkg::OP_CLOSE: k <= '0;
        gaps_pkg::OP_NB_RD: begin
          n_r  <= nr_s[PW-1:0];
          n_c  <= nc_s[PW-1:0];
          n_in <= nb_in;
        end
        gaps_pkg::OP_NB_EV: begin
          k <= k + 1'b1;
          if (n_use && n_goal) begin
            res_status  <= gaps_pkg::ST_FOUND;
            res_cost    <= (ng > (CW+1)'(gaps_pkg::COST_MAX)) ? gaps_pkg::COST_MAX : ng[CW-1:0];
            res_dir     <= '0;
            res_reached <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == gaps_pkg::OP_EMIT) begin
      status     <= res_status;
      path_cost  <= res_cost;
      parent_dir <= res_dir;
      reached    <= res_reached;
    end
  end

endmodule
`default_nettype wire

// ----- src/grid_astar_path_search_core.sv -----
// Top level of the grid A* path search core.
// Depends on gaps_pkg, gaps_ctrl and gaps_datapath.
`timescale 1ns / 1ps
`default_nettype none
// The core holds a 64 x 64 grid of free/blocked cells and runs an A* search
// (8 neighbours, unit steps, Manhattan heuristic, ties to the lowest
// row-major index) from the start cell to the goal cell set in the config
// registers. Each input word is a cell write (mode 0), a search (mode 1) or
// a parent read (mode 2); mode 3 is dropped with no result. After reset the
// core sweeps the grid to clear all cells to blocked and accepts no word
// meanwhile (config writes are taken). A write holds the core through its
// write state and a read through its read and evaluate states; each then
// waits in the emit state until the output register is free. A search first
// sweeps the marks, checks start and goal, and then per expanded cell scans
// the open set through the single grid read port, picks and closes the best
// cell and visits up to 8 neighbours (one read and one update each). The
// result sits in an output register, so the next word is accepted while it
// waits. Config writes are meant only while the core is idle.
module grid_astar_path_search_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [gaps_pkg::CFGI_W-1:0]  cfg_index,
  input  wire logic [gaps_pkg::CFG_W-1:0]   cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [1:0]                   mode,
  input  wire logic [gaps_pkg::POS_W-1:0]   cell_row,
  input  wire logic [gaps_pkg::POS_W-1:0]   cell_col,
  input  wire logic                         passable,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [2:0]                        status,
  output logic [gaps_pkg::COST_W-1:0]       path_cost,
  output logic [2:0]                        parent_dir,
  output logic                              reached
);

  gaps_pkg::gaps_cmd_t  cmd;
  gaps_pkg::gaps_stat_t stat;

  gaps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .mode     (mode),
    .stat     (stat),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  gaps_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cell_row   (cell_row),
    .cell_col   (cell_col),
    .passable   (passable),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .path_cost  (path_cost),
    .parent_dir (parent_dir),
    .reached    (reached)
  );

  // reset starts the clearing sweep, no word taken right after
  a_reset_sweep: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("word accepted during reset sweep");

  // a word with a result keeps intake closed on the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (mode != gaps_pkg::MODE_NONE)) |=> !in_ready)
    else $error("intake open while a word is in work");

  // a result appears only from the emit command
  a_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.op == gaps_pkg::OP_EMIT))
    else $error("result without emit");

endmodule
`default_nettype wire

// ----- tb/path_search_checker.sv -----
// Checker of the grid path search core: watches config writes and both word channels.
// Holds its own grid, cost and mark state and compares each result word with its prediction.
// Depends on gaps_pkg.
`timescale 1ns / 1ps
module path_search_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [gaps_pkg::CFGI_W-1:0] cfg_index,
  input  logic [gaps_pkg::CFG_W-1:0]  cfg_data,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [1:0]                  mode,
  input  logic [5:0]                  cell_row,
  input  logic [5:0]                  cell_col,
  input  logic                        passable,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [2:0]                  status,
  input  logic [11:0]                 path_cost,
  input  logic [2:0]                  parent_dir,
  input  logic                        reached,
  output int                          mismatches,
  output int                          pending
);
  import gaps_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] cost;
    logic [2:0]  dir;
    logic        reached;
  } path_word_t;

  path_word_t  awaited_words[$];
  logic [6:0]  rows_q, cols_q;
  logic [5:0]  start_r, start_c, goal_r, goal_c;
  bit          free_map[CELLS];
  int unsigned g_cost[CELLS];
  logic [1:0]  mark_map[CELLS];
  logic [2:0]  toward_parent[CELLS];

  function automatic int eff_dim(input logic [6:0] v);
    eff_dim = (v > MAX_DIM) ? MAX_DIM : int'(v);
  endfunction

  function automatic bit on_grid(input int r, input int c);
    on_grid = r >= 0 && c >= 0 && r < eff_dim(rows_q) && c < eff_dim(cols_q);
  endfunction

  function automatic bit open_cell(input int r, input int c);
    open_cell = on_grid(r, c) && free_map[r * MAX_DIM + c];
  endfunction

  function automatic int unsigned dist_to_goal(input int r, input int c);
    int a, b;
    a = r - int'(goal_r);
    b = c - int'(goal_c);
    dist_to_goal = (a < 0 ? -a : a) + (b < 0 ? -b : b);
  endfunction

  // A* over the grid; returns the status word and the goal cost
  function automatic logic [2:0] astar(output int unsigned cost);
    int sr, sc, gr, gc, br, bc, nr, nc, na, ca;
    int unsigned best_f, f, ng;
    bit any;
    sr = start_r; sc = start_c; gr = goal_r; gc = goal_c;
    cost = 0;
    for (int i = 0; i < CELLS; i++) mark_map[i] = MARK_UNSEEN;
    if (!open_cell(sr, sc) || !open_cell(gr, gc)) return ST_INVALID;
    g_cost[sr * MAX_DIM + sc] = 0;
    toward_parent[sr * MAX_DIM + sc] = 0;
    if (sr == gr && sc == gc) begin
      mark_map[sr * MAX_DIM + sc] = MARK_CLOSED;
      return ST_FOUND;
    end
    mark_map[sr * MAX_DIM + sc] = MARK_OPEN;
    forever begin
      any = 0; best_f = 0; br = 0; bc = 0;
      for (int r = 0; r < eff_dim(rows_q); r++)
        for (int c = 0; c < eff_dim(cols_q); c++) begin
          if (mark_map[r * MAX_DIM + c] == MARK_OPEN) begin
            f = g_cost[r * MAX_DIM + c] + dist_to_goal(r, c);
            if (!any || f < best_f) begin
              any = 1; best_f = f; br = r; bc = c;
            end
          end
        end
      if (!any) return ST_NOPATH;
      ca = br * MAX_DIM + bc;
      mark_map[ca] = MARK_CLOSED;
      ng = g_cost[ca] + 1;
      for (int k = 0; k < 8; k++) begin
        nr = br + ROW_OFF[k];
        nc = bc + COL_OFF[k];
        if (open_cell(nr, nc)) begin
          na = nr * MAX_DIM + nc;
          if (nr == gr && nc == gc) begin
            g_cost[na] = ng;
            toward_parent[na] = REV_DIR[k];
            mark_map[na] = MARK_CLOSED;
            cost = ng;
            return ST_FOUND;
          end
          // closed cells reopen on a cheaper path
          if (mark_map[na] == MARK_UNSEEN || ng < g_cost[na]) begin
            g_cost[na] = ng;
            toward_parent[na] = REV_DIR[k];
            mark_map[na] = MARK_OPEN;
          end
        end
      end
    end
  endfunction

  function automatic path_word_t predict_word(input logic [1:0] m, input int r, input int c,
                                              input logic p);
    path_word_t w;
    int unsigned cost;
    w = '0;
    cost = 0;
    case (m)
      MODE_WRITE: begin
        free_map[r * MAX_DIM + c] = p;
        w.status = ST_WRITTEN;
      end
      MODE_SEARCH: w.status = astar(cost);
      default: begin
        w.status = ST_PARENT;
        if (on_grid(r, c) && mark_map[r * MAX_DIM + c] != MARK_UNSEEN) begin
          w.reached = 1;
          cost = g_cost[r * MAX_DIM + c];
          w.dir = toward_parent[r * MAX_DIM + c];
        end
      end
    endcase
    w.cost = (cost > COST_MAX) ? COST_MAX : cost[11:0];
    return w;
  endfunction

  always @(posedge clk) begin
    path_word_t want;
    if (rst) begin
      rows_q = 64; cols_q = 64;
      start_r = 0; start_c = 0; goal_r = 0; goal_c = 0;
      for (int i = 0; i < CELLS; i++) begin
        free_map[i] = 0; g_cost[i] = 0; mark_map[i] = MARK_UNSEEN; toward_parent[i] = 0;
      end
      awaited_words.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ROWS:      rows_q  = cfg_data;
          REG_COLS:      cols_q  = cfg_data;
          REG_START_ROW: start_r = cfg_data[5:0];
          REG_START_COL: start_c = cfg_data[5:0];
          REG_GOAL_ROW:  goal_r  = cfg_data[5:0];
          REG_GOAL_COL:  goal_c  = cfg_data[5:0];
          default: ;
        endcase
      end
      // result first: a word taken at this edge cannot answer itself
      if (out_valid && out_ready) begin
        if (awaited_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word status=%0d", status);
        end else begin
          want = awaited_words.pop_front();
          if (want.status !== status || want.cost !== path_cost ||
              want.dir !== parent_dir || want.reached !== reached) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp st=%0d cost=%0d dir=%0d rch=%0d, got %0d %0d %0d %0d",
                       want.status, want.cost, want.dir, want.reached,
                       status, path_cost, parent_dir, reached);
          end
        end
      end
      if (in_valid && in_ready && mode != MODE_NONE)
        awaited_words = {awaited_words, predict_word(mode, cell_row, cell_col, passable)};
    end
    pending = awaited_words.size();
  end

endmodule

// ----- tb/testbench.sv -----
// Top of the grid path search core testbench: clock, reset, stimulus and verdict.
// Depends on gaps_pkg, grid_astar_path_search_core and path_search_checker.
`timescale 1ns / 1ps
module testbench;
  import gaps_pkg::*;

  // Slowest runs: each search sweeps 4096 marks, then scans every grid cell per
  // expansion. Most grids are 8x8 or less, large grids only search from a
  // cell next to the goal.
  localparam int CYCLE_CAP = 20_000_000;
  localparam int WORD_GOAL = 1450;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = '0;
  logic [6:0]  cfg_data = '0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  mode = MODE_WRITE;
  logic [5:0]  cell_row = '0;
  logic [5:0]  cell_col = '0;
  logic        passable = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [2:0]  status;
  logic [11:0] path_cost;
  logic [2:0]  parent_dir;
  logic        reached;
  int          mismatches;
  int          pending;
  int          words_sent = 0;
  int          cycles = 0;
  bit          calm = 0;   // phases with no idling on either side

  always #10 clk = ~clk;

  grid_astar_path_search_core u_dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .mode, .cell_row, .cell_col, .passable,
    .out_valid, .out_ready, .status, .path_cost, .parent_dir, .reached
  );

  path_search_checker u_checker (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .mode, .cell_row, .cell_col, .passable,
    .out_valid, .out_ready, .status, .path_cost, .parent_dir, .reached,
    .mismatches, .pending
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("testbench failed");
      $finish;
    end
  end

  // result side: random stall before each word
  initial begin
    int gap;
    while (rst) @(negedge clk);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        out_ready = 0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // one input word; valid stays up into the next word when there is no gap
  task automatic send_word(input logic [1:0] m, input int r, input int c, input bit p);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid = 0;
      repeat (gap) @(negedge clk);
    end
    mode = m;
    cell_row = r[5:0];
    cell_col = c[5:0];
    passable = p;
    in_valid = 1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (m != MODE_NONE) words_sent++;
  endtask

  // idle wait until no result is pending, followed by extra idle cycles
  task automatic drain;
    in_valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input int v);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = v[6:0];
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic set_grid(input int rows, input int cols, input int sr, input int sc,
                          input int gr, input int gc);
    write_reg(REG_ROWS, rows);
    write_reg(REG_COLS, cols);
    write_reg(REG_START_ROW, sr);
    write_reg(REG_START_COL, sc);
    write_reg(REG_GOAL_ROW, gr);
    write_reg(REG_GOAL_COL, gc);
  endtask

  task automatic random_phase;
    int kind, rows, cols, sr, sc, gr, gc, hr, hc, nsearch;
    drain();
    kind = $urandom_range(0, 99);
    calm = ($urandom_range(0, 3) == 0);
    if (kind < 80) begin
      rows = $urandom_range(1, 8); cols = $urandom_range(1, 8);
    end else if (kind < 93) begin
      rows = $urandom_range(1, 16); cols = $urandom_range(1, 16);
    end else if (kind < 97) begin
      rows = $urandom_range(0, 1) ? 64 : 127;
      cols = $urandom_range(0, 1) ? 64 : 127;
    end else begin
      rows = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
      cols = (rows == 0) ? $urandom_range(0, 8) : 0;
    end
    hr = (rows > 64) ? 64 : rows;
    hc = (cols > 64) ? 64 : cols;
    if (hr == 64 && hc == 64) begin
      // big grid: goal at most one step away keeps the search to one scan
      sr = $urandom_range(0, 62); sc = $urandom_range(0, 62);
      gr = sr + $urandom_range(0, 1); gc = sc + $urandom_range(0, 1);
    end else if (hr > 0 && hc > 0 && $urandom_range(0, 9) != 0) begin
      sr = $urandom_range(0, hr - 1); sc = $urandom_range(0, hc - 1);
      gr = $urandom_range(0, hr - 1); gc = $urandom_range(0, hc - 1);
    end else begin
      sr = $urandom_range(0, 63); sc = $urandom_range(0, 63);
      gr = $urandom_range(0, 63); gc = $urandom_range(0, 63);
    end
    set_grid(rows, cols, sr, sc, gr, gc);
    if (hr < 64 || hc < 64)
      for (int r = 0; r < hr; r++)
        for (int c = 0; c < hc; c++)
          if ($urandom_range(0, 4) != 0) send_word(MODE_WRITE, r, c, $urandom_range(0, 3) != 0);
    // noise anywhere in the store, and a dropped word now and then
    repeat ($urandom_range(0, 2))
      send_word(MODE_WRITE, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 1));
    if ($urandom_range(0, 4) == 0) send_word(MODE_NONE, $urandom_range(0, 63),
                                             $urandom_range(0, 63), $urandom_range(0, 1));
    // start and goal mostly free, sometimes blocked
    send_word(MODE_WRITE, sr, sc, $urandom_range(0, 7) != 0);
    send_word(MODE_WRITE, gr, gc, $urandom_range(0, 7) != 0);
    nsearch = $urandom_range(1, 2);
    for (int s = 0; s < nsearch; s++) begin
      if (s > 0 && hr > 0 && hc > 0 && (hr < 64 || hc < 64))
        send_word(MODE_WRITE, $urandom_range(0, hr - 1), $urandom_range(0, hc - 1),
                  $urandom_range(0, 1));
      send_word(MODE_SEARCH, $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 1));
      send_word(MODE_READ, gr, gc, $urandom_range(0, 1));
      repeat (6) begin
        if (hr > 0 && hc > 0 && $urandom_range(0, 4) != 0)
          send_word(MODE_READ, $urandom_range(0, hr - 1), $urandom_range(0, hc - 1),
                    $urandom_range(0, 1));
        else
          send_word(MODE_READ, $urandom_range(0, 63), $urandom_range(0, 63),
                    $urandom_range(0, 1));
      end
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst = 0;

    // directed: reset config is 64x64 with start = goal = (0,0), all blocked
    send_word(MODE_SEARCH, 0, 0, 0);      // blocked start
    send_word(MODE_WRITE, 0, 0, 1);
    send_word(MODE_SEARCH, 63, 63, 1);    // start equals goal
    send_word(MODE_READ, 0, 0, 0);
    send_word(MODE_READ, 63, 63, 1);      // never reached
    send_word(MODE_WRITE, 63, 63, 1);
    send_word(MODE_WRITE, 63, 62, 0);
    send_word(MODE_NONE, 63, 63, 1);      // dropped
    drain();
    set_grid(0, 64, 0, 0, 0, 0);          // empty grid
    send_word(MODE_SEARCH, 0, 0, 0);
    send_word(MODE_READ, 0, 0, 0);
    drain();
    set_grid(127, 127, 62, 62, 63, 63);   // oversize saturates to 64
    send_word(MODE_WRITE, 62, 62, 1);
    send_word(MODE_SEARCH, 0, 0, 0);
    send_word(MODE_READ, 63, 63, 0);
    send_word(MODE_READ, 62, 62, 0);
    drain();
    set_grid(3, 3, 0, 0, 2, 2);           // wall down the middle column
    send_word(MODE_WRITE, 2, 2, 1);
    send_word(MODE_WRITE, 0, 1, 0);
    send_word(MODE_WRITE, 1, 1, 0);
    send_word(MODE_WRITE, 2, 1, 0);
    send_word(MODE_SEARCH, 0, 0, 0);      // no path
    send_word(MODE_READ, 1, 0, 0);
    send_word(MODE_READ, 5, 5, 0);        // outside the grid
    drain();
    write_reg(REG_GOAL_ROW, 5);           // goal off the grid
    send_word(MODE_SEARCH, 0, 0, 0);

    while (words_sent < WORD_GOAL) random_phase();

    drain();
    repeat (100) @(negedge clk);
    if (mismatches == 0 && pending == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule
